/* rtl/core/occt_pkg.sv */
// Shared types and constants for the OOK remote code transmitter.
// Used by every module of the block; no dependencies.
package occt_pkg;

	// Fixed field widths
	localparam int ACTION_W     = 2;
	localparam int CODE_W       = 32;
	localparam int IDX_W        = 5;
	localparam int SYM_BITS_MAX = 8;
	localparam int TIMER_W      = 16;
	localparam int UNIT_W       = 15;
	localparam int REPEAT_W     = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	// Default geometry of the symbol buffer
	localparam int DEF_SYMBOL_COUNT = 31;
	localparam int DEF_SYMBOL_BITS  = 5;

	// Action codes carried in the input kind
	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CODE   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_SYM_WR = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_SYM_GO = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_END_LOW    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT       = 3'd6;

	// Configuration reset values
	localparam logic [REPEAT_W-1:0] RST_REPEAT     = 8'd10;
	localparam logic [TIMER_W-1:0]  RST_PULSE_HIGH = 16'd220;
	localparam logic [TIMER_W-1:0]  RST_SHORT_LOW  = 16'd320;
	localparam logic [TIMER_W-1:0]  RST_LONG_LOW   = 16'd1330;
	localparam logic [TIMER_W-1:0]  RST_START_LOW  = 16'd2700;
	localparam logic [TIMER_W-1:0]  RST_END_LOW    = 16'd10270;
	localparam logic [UNIT_W-1:0]   RST_UNIT       = 15'h100;

	// Timing configuration
	typedef struct packed {
		logic [REPEAT_W-1:0] repeat_count;
		logic [TIMER_W-1:0]  pulse_high_ticks;
		logic [TIMER_W-1:0]  short_low_ticks;
		logic [TIMER_W-1:0]  long_low_ticks;
		logic [TIMER_W-1:0]  start_low_ticks;
		logic [TIMER_W-1:0]  end_low_ticks;
		logic [UNIT_W-1:0]   unit_ticks;
	} cfg_t;

	// Classified input item, front to back
	typedef struct packed {
		logic [ACTION_W-1:0]     action;
		logic [CODE_W-1:0]       code;
		logic [IDX_W-1:0]        symbol_index;
		logic [SYM_BITS_MAX-1:0] symbol_value;
		logic                    code_bad;
		logic                    idx_bad;
	} item_t;

	// One result item
	typedef struct packed {
		logic rejected;
		logic done_res;
		logic busy_res;
		logic line_level;
	} res_t;

endpackage

/* rtl/core/occt_front.sv */
// Front stage: accepts input items, flags bad codes and indexes, registers them.
// Depends on occt_pkg.
module occt_front #(
	parameter int SYMBOL_COUNT = occt_pkg::DEF_SYMBOL_COUNT,
	parameter int SYMBOL_BITS  = occt_pkg::DEF_SYMBOL_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [occt_pkg::ACTION_W-1:0]   action,
	input  logic [occt_pkg::CODE_W-1:0]     code,
	input  logic [occt_pkg::IDX_W-1:0]      symbol_index,
	input  logic [SYMBOL_BITS-1:0]          symbol_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output occt_pkg::item_t                 out_item
);
	import occt_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;

	// Classification: code must be nonzero and below 2^28
	always_comb begin
		item_c              = '0;
		item_c.action       = action;
		item_c.code         = code;
		item_c.symbol_index = symbol_index;
		item_c.symbol_value = SYM_BITS_MAX'(symbol_value);
		item_c.code_bad     = (code == '0) || (code[CODE_W-1:28] != '0);
		item_c.idx_bad      = (int'(symbol_index) >= SYMBOL_COUNT);
	end

	assign in_ready = !valid_s1 || out_ready;

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

/* rtl/core/occt_queue.sv */
// Two-entry item queue between the front and the back.
// Depends on occt_pkg.
module occt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  occt_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output occt_pkg::item_t pop_item
);
	import occt_pkg::*;

	localparam int DEPTH = 2;

	item_t      mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'(DEPTH));
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/core/occt_back.sv */
// Back end: segment sequencer, symbol buffer and result register.
// Depends on occt_pkg; fed by occt_queue.
module occt_back #(
	parameter int SYMBOL_COUNT = occt_pkg::DEF_SYMBOL_COUNT,
	parameter int SYMBOL_BITS  = occt_pkg::DEF_SYMBOL_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  occt_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  occt_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output occt_pkg::res_t  out_res
);
	import occt_pkg::*;

	localparam int AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int SPW = $clog2(SYMBOL_COUNT + 1);

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_CODE = 2'd1;
	localparam logic [1:0] MODE_SYM  = 2'd2;

	// Segment steps; symbol mode reuses them as lead, gap, mark, gap, bit, gap, close
	localparam logic [2:0] ST_LEAD_HI  = 3'd0;
	localparam logic [2:0] ST_LEAD_LO  = 3'd1;
	localparam logic [2:0] ST_HALF1_HI = 3'd2;
	localparam logic [2:0] ST_HALF1_LO = 3'd3;
	localparam logic [2:0] ST_HALF2_HI = 3'd4;
	localparam logic [2:0] ST_HALF2_LO = 3'd5;
	localparam logic [2:0] ST_END_HI   = 3'd6;
	localparam logic [2:0] ST_END_LO   = 3'd7;

	typedef struct packed {
		logic               level;
		logic [TIMER_W-1:0] dur;
	} seg_t;

	// Level and length of a segment on entry
	function automatic seg_t seg_f(input logic [1:0] m, input logic [2:0] st,
			input cfg_t c, input logic cbit, input logic sbit);
		seg_t               s;
		logic [TIMER_W-1:0] u;
		u = TIMER_W'(c.unit_ticks);
		s = '0;
		if (m == MODE_CODE) begin
			unique case (st)
				ST_LEAD_LO:  s = '{1'b0, c.start_low_ticks};
				ST_HALF1_LO: s = '{1'b0, cbit ? c.long_low_ticks : c.short_low_ticks};
				ST_HALF2_LO: s = '{1'b0, cbit ? c.short_low_ticks : c.long_low_ticks};
				ST_END_LO:   s = '{1'b0, c.end_low_ticks};
				default:     s = '{1'b1, c.pulse_high_ticks};
			endcase
		end else begin
			unique case (st)
				ST_LEAD_HI:             s = '{1'b1, {c.unit_ticks, 1'b0}};
				ST_HALF1_HI, ST_END_HI: s = '{1'b1, u};
				ST_HALF2_HI:            s = '{sbit, u};
				default:                s = '{1'b0, u};
			endcase
		end
		if (s.dur == '0) s.dur = TIMER_W'(1);
		return s;
	endfunction

	// Sequencer state
	logic [1:0]          mode_q;
	logic [2:0]          step_q;
	logic [TIMER_W-1:0]  timer_q;
	logic [CODE_W-1:0]   code_q;
	logic [5:0]          bitpos_q;
	logic [REPEAT_W-1:0] repeats_q;
	logic [SPW-1:0]      sympos_q;
	logic                line_q;

	// Symbol buffer, registered read at the current symbol
	logic [SYMBOL_BITS-1:0] sym_mem [SYMBOL_COUNT];
	logic [SYMBOL_BITS-1:0] sym_rd_q;
	logic [SYMBOL_BITS-1:0] sym_sh;

	logic   out_valid_q;
	res_t   out_res_q;
	logic   pop;

	// After the command of this item
	logic [1:0]          mode_c;
	logic [2:0]          step_c;
	logic [TIMER_W-1:0]  timer_c;
	logic [CODE_W-1:0]   code_c;
	logic [5:0]          bitpos_c;
	logic [REPEAT_W-1:0] repeats_c;
	logic [SPW-1:0]      sympos_c;
	logic                line_c;
	// After this tick
	logic [1:0]          mode_n;
	logic [2:0]          step_n;
	logic [TIMER_W-1:0]  timer_n;
	logic [5:0]          bitpos_n;
	logic [REPEAT_W-1:0] repeats_n;
	logic [SPW-1:0]      sympos_n;
	logic                line_n;
	logic [TIMER_W-1:0]  timer_d;
	logic [2:0]          nstep;
	logic                enter;
	logic                rej;
	logic                done;
	logic                lvl;
	logic                wr_en;
	seg_t                seg0;
	seg_t                segn;

	assign pop      = in_valid && (!out_valid_q || out_ready);
	assign in_ready = !out_valid_q || out_ready;
	assign sym_sh   = sym_rd_q << bitpos_n;

	// Command phase
	always_comb begin
		mode_c    = mode_q;
		step_c    = step_q;
		timer_c   = timer_q;
		code_c    = code_q;
		bitpos_c  = bitpos_q;
		repeats_c = repeats_q;
		sympos_c  = sympos_q;
		line_c    = line_q;
		rej       = 1'b0;
		wr_en     = 1'b0;
		seg0      = seg_f(in_item.action == ACT_CODE ? MODE_CODE : MODE_SYM, ST_LEAD_HI,
				cfg, 1'b0, 1'b0);
		if (in_item.action != ACT_TICK) begin
			if (mode_q != MODE_IDLE) begin
				rej = 1'b1;
			end else begin
				unique case (in_item.action)
					ACT_CODE: begin
						if (in_item.code_bad) begin
							rej = 1'b1;
						end else begin
							mode_c    = MODE_CODE;
							code_c    = in_item.code;
							bitpos_c  = '0;
							repeats_c = (cfg.repeat_count != '0) ? cfg.repeat_count
									: REPEAT_W'(1);
							step_c    = ST_LEAD_HI;
							line_c    = seg0.level;
							timer_c   = seg0.dur;
						end
					end
					ACT_SYM_WR: begin
						if (in_item.idx_bad) rej = 1'b1;
						else wr_en = 1'b1;
					end
					ACT_SYM_GO: begin
						mode_c   = MODE_SYM;
						sympos_c = '0;
						bitpos_c = '0;
						step_c   = ST_LEAD_HI;
						line_c   = seg0.level;
						timer_c  = seg0.dur;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Tick phase: count down, move to the next segment
	always_comb begin
		mode_n    = mode_c;
		step_n    = step_c;
		timer_n   = timer_c;
		bitpos_n  = bitpos_c;
		repeats_n = repeats_c;
		sympos_n  = sympos_c;
		line_n    = line_c;
		done      = 1'b0;
		lvl       = 1'b0;
		enter     = 1'b0;
		nstep     = step_c + 3'd1;
		timer_d   = (timer_c != '0) ? timer_c - TIMER_W'(1) : timer_c;
		if (mode_c != MODE_IDLE) begin
			lvl     = line_c;
			timer_n = timer_d;
			if (timer_d == '0) begin
				enter = 1'b1;
				if (step_c == ST_HALF2_LO) begin
					bitpos_n = bitpos_c + 6'd1;
					if (mode_c == MODE_CODE) begin
						nstep = (bitpos_n < 6'd32) ? ST_HALF1_HI : ST_END_HI;
					end else if (int'(bitpos_n) < SYMBOL_BITS) begin
						nstep = ST_HALF2_HI;
					end else begin
						sympos_n = sympos_c + SPW'(1);
						bitpos_n = '0;
						nstep    = (int'(sympos_n) < SYMBOL_COUNT) ? ST_LEAD_HI : ST_END_HI;
					end
				end else if (step_c == ST_END_LO) begin
					if (mode_c == MODE_CODE) repeats_n = repeats_c - REPEAT_W'(1);
					if (mode_c == MODE_CODE && repeats_n != '0) begin
						bitpos_n = '0;
						nstep    = ST_LEAD_HI;
					end else begin
						enter   = 1'b0;
						mode_n  = MODE_IDLE;
						step_n  = ST_LEAD_HI;
						timer_n = '0;
						line_n  = 1'b0;
						done    = 1'b1;
					end
				end
			end
		end
		segn = seg_f(mode_c, nstep, cfg, code_c[~bitpos_c[4:0]], sym_sh[SYMBOL_BITS-1]);
		if (enter) begin
			step_n  = nstep;
			line_n  = segn.level;
			timer_n = segn.dur;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			step_q      <= ST_LEAD_HI;
			timer_q     <= '0;
			code_q      <= '0;
			bitpos_q    <= '0;
			repeats_q   <= '0;
			sympos_q    <= '0;
			line_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q      <= mode_n;
				step_q      <= step_n;
				timer_q     <= timer_n;
				code_q      <= code_c;
				bitpos_q    <= bitpos_n;
				repeats_q   <= repeats_n;
				sympos_q    <= sympos_n;
				line_q      <= line_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= '{rej, done, (mode_n != MODE_IDLE), lvl};
		end
	end

	// Symbol buffer write and read
	always_ff @(posedge clk) begin
		if (pop && wr_en) begin
			sym_mem[AW'(in_item.symbol_index)] <= in_item.symbol_value[SYMBOL_BITS-1:0];
		end
		sym_rd_q <= sym_mem[sympos_q[AW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

/* rtl/core/ook_remote_code_transmitter_top.sv */
// Top level of the OOK remote code transmitter: ports, configuration registers.
// Depends on occt_pkg, occt_front, occt_queue and occt_back.
//
// Channel   Direction  Signals                         Content
// s_*       in         s_tvalid/s_tready/s_tdata/user  tick or command, one per tick
// m_*       out        m_tvalid/m_tready/m_tdata       line level and status per item
// cfg_*     in         cfg_we/cfg_index/cfg_data       timing register writes
//
// One item per clock sustained while m_tready stays high; m_tvalid for an item
// rises once it has passed the front register, the queue and the result register.
// The back end's segment sequencer retires one item per clock unless stalled.
// Reset clears control state and loads the timing defaults; the symbol buffer
// holds no reset value. A stalled result holds the back end; the two-entry
// queue and the front register then fill and s_tready drops.
module ook_remote_code_transmitter_top #(
	parameter int SYMBOL_COUNT = occt_pkg::DEF_SYMBOL_COUNT,
	parameter int SYMBOL_BITS  = occt_pkg::DEF_SYMBOL_BITS,
	localparam int IN_DATA_W   = ((occt_pkg::CODE_W + occt_pkg::IDX_W + SYMBOL_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// code [31:0], symbol_index [36:32], symbol_value above, zero fill
	input  logic [IN_DATA_W-1:0]              s_tdata,
	// action
	input  logic [occt_pkg::ACTION_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// line_level [0], busy_res [1], done_res [2], rejected [3], zero fill
	output logic [7:0]                        m_tdata,
	input  logic                              cfg_we,
	input  logic [occt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [occt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import occt_pkg::*;

	cfg_t  cfg_q;
	item_t f_item;
	item_t q_item;
	res_t  res;
	logic  f_valid;
	logic  f_ready;
	logic  q_valid;
	logic  q_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_count     <= RST_REPEAT;
			cfg_q.pulse_high_ticks <= RST_PULSE_HIGH;
			cfg_q.short_low_ticks  <= RST_SHORT_LOW;
			cfg_q.long_low_ticks   <= RST_LONG_LOW;
			cfg_q.start_low_ticks  <= RST_START_LOW;
			cfg_q.end_low_ticks    <= RST_END_LOW;
			cfg_q.unit_ticks       <= RST_UNIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REPEAT:     cfg_q.repeat_count     <= cfg_data[REPEAT_W-1:0];
				REG_PULSE_HIGH: cfg_q.pulse_high_ticks <= cfg_data;
				REG_SHORT_LOW:  cfg_q.short_low_ticks  <= cfg_data;
				REG_LONG_LOW:   cfg_q.long_low_ticks   <= cfg_data;
				REG_START_LOW:  cfg_q.start_low_ticks  <= cfg_data;
				REG_END_LOW:    cfg_q.end_low_ticks    <= cfg_data;
				REG_UNIT:       cfg_q.unit_ticks       <= cfg_data[UNIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	occt_front #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.action      (s_tuser),
		.code        (s_tdata[CODE_W-1:0]),
		.symbol_index(s_tdata[CODE_W+IDX_W-1:CODE_W]),
		.symbol_value(s_tdata[CODE_W+IDX_W+SYMBOL_BITS-1:CODE_W+IDX_W]),
		.out_valid   (f_valid),
		.out_ready   (f_ready),
		.out_item    (f_item)
	);

	occt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_item (f_item),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_item  (q_item)
	);

	occt_back #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {4'b0, res.rejected, res.done_res, res.busy_res, res.line_level};

`ifndef ASSERT_OFF
	// A finishing tick leaves the block idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[1]))
		else $error("done reported while still busy");

	// Carrier only while a transmission runs
	a_line_needs_tx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[1] || m_tdata[2]))
		else $error("line high outside a transmission");

	// The back end never takes an item while its result slot is blocked
	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !q_ready)
		else $error("back end advanced during an output stall");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for the OOK remote code transmitter: directed and random tick and
// command streams, each result item checked against an in-bench line sequencer model.
// Depends on occt_pkg and ook_remote_code_transmitter_top.
module tb_top;
	import occt_pkg::*;

	localparam int SYMBOLS       = DEF_SYMBOL_COUNT;
	localparam int SYM_W         = DEF_SYMBOL_BITS;
	localparam int DATA_W        = ((CODE_W + IDX_W + SYM_W + 7) / 8) * 8;
	localparam int CODE_TOP_BIT  = 28;       // codes at or above 2^28 are refused
	localparam int MAX_CYCLES    = 20_000;
	localparam int PIPE_SLACK    = 6;
	localparam int HOLD_ITEMS    = 24;

	// Segment slots of one frame; meaning differs per mode
	localparam logic [2:0] SEG_HEAD_HI = 3'd0;
	localparam logic [2:0] SEG_HEAD_LO = 3'd1;
	localparam logic [2:0] SEG_A_HI    = 3'd2;
	localparam logic [2:0] SEG_A_LO    = 3'd3;
	localparam logic [2:0] SEG_B_HI    = 3'd4;
	localparam logic [2:0] SEG_B_LO    = 3'd5;
	localparam logic [2:0] SEG_END_HI  = 3'd6;
	localparam logic [2:0] SEG_END_LO  = 3'd7;

	typedef enum logic [1:0] {TX_IDLE, TX_CODE, TX_SYM} tx_mode_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [DATA_W-1:0]     s_tdata   = '0;
	logic [ACTION_W-1:0]   s_tuser   = ACT_TICK;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_REPEAT;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int hold_left     = 0;
	int cycle_count   = 0;
	int mismatches    = 0;
	res_t expected_line_states[$];

	// Model copy of timing registers and sequencer state
	cfg_t             tx_cfg;
	tx_mode_e         tx_mode;
	logic [2:0]       tx_step;
	logic [15:0]      tx_timer;
	logic [31:0]      tx_code;
	logic [5:0]       tx_bit;
	logic [7:0]       tx_reps;
	logic [SYM_W-1:0] tx_syms [SYMBOLS];
	logic [IDX_W-1:0] tx_sym_pos;
	logic             tx_line;

	ook_remote_code_transmitter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Result checker
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[3:0];
			if (expected_line_states.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %b at cycle %0d", m_tdata, cycle_count);
			end else begin
				want = expected_line_states.pop_front();
				if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
				    got.done_res !== want.done_res || got.rejected !== want.rejected ||
				    m_tdata[7:4] !== 4'd0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at cycle %0d: exp line=%b busy=%b done=%b rej=%b, %s%b",
						         cycle_count, want.line_level, want.busy_res, want.done_res,
						         want.rejected, "got tdata=", m_tdata);
				end
			end
		end
	end

	// ---------------- line sequencer model ----------------

	function automatic void model_reset();
		tx_cfg.repeat_count     = RST_REPEAT;
		tx_cfg.pulse_high_ticks = RST_PULSE_HIGH;
		tx_cfg.short_low_ticks  = RST_SHORT_LOW;
		tx_cfg.long_low_ticks   = RST_LONG_LOW;
		tx_cfg.start_low_ticks  = RST_START_LOW;
		tx_cfg.end_low_ticks    = RST_END_LOW;
		tx_cfg.unit_ticks       = RST_UNIT;
		tx_mode     = TX_IDLE;
		tx_step     = SEG_HEAD_HI;
		tx_timer    = '0;
		tx_code     = '0;
		tx_bit      = '0;
		tx_reps     = '0;
		tx_sym_pos  = '0;
		tx_line     = 1'b0;
	endfunction

	function automatic logic code_bit_now();
		return tx_code[5'd31 - tx_bit[4:0]];
	endfunction

	function automatic logic sym_bit_now();
		if (tx_sym_pos >= SYMBOLS || tx_bit >= SYM_W)
			return 1'b0;
		return tx_syms[tx_sym_pos][SYM_W - 1 - tx_bit];
	endfunction

	// Zero length acts as one tick
	function automatic void load_seg(input logic level, input logic [15:0] dur);
		tx_line  = level;
		tx_timer = (dur == '0) ? 16'd1 : dur;
	endfunction

	function automatic void enter_seg(input logic [2:0] step);
		logic [15:0] u;
		u = {1'b0, tx_cfg.unit_ticks};
		tx_step = step;
		if (tx_mode == TX_CODE) begin
			case (step)
				SEG_HEAD_LO: load_seg(1'b0, tx_cfg.start_low_ticks);
				SEG_A_LO: load_seg(1'b0, code_bit_now() ? tx_cfg.long_low_ticks
				                                        : tx_cfg.short_low_ticks);
				SEG_B_LO: load_seg(1'b0, code_bit_now() ? tx_cfg.short_low_ticks
				                                        : tx_cfg.long_low_ticks);
				SEG_END_LO: load_seg(1'b0, tx_cfg.end_low_ticks);
				default: load_seg(1'b1, tx_cfg.pulse_high_ticks);
			endcase
		end else begin
			case (step)
				SEG_HEAD_HI: load_seg(1'b1, u << 1);
				SEG_A_HI, SEG_END_HI: load_seg(1'b1, u);
				SEG_B_HI: load_seg(sym_bit_now(), u);
				default: load_seg(1'b0, u);
			endcase
		end
	endfunction

	// Step to the next segment; 1 when the transmission is over
	function automatic logic next_seg();
		if (tx_step == SEG_B_LO) begin
			tx_bit++;
			if (tx_mode == TX_CODE) begin
				enter_seg(tx_bit < CODE_W ? SEG_A_HI : SEG_END_HI);
			end else if (tx_bit < SYM_W) begin
				enter_seg(SEG_B_HI);
			end else begin
				tx_sym_pos++;
				tx_bit = '0;
				enter_seg(tx_sym_pos < SYMBOLS ? SEG_HEAD_HI : SEG_END_HI);
			end
			return 1'b0;
		end
		if (tx_step == SEG_END_LO) begin
			if (tx_mode == TX_CODE) begin
				tx_reps--;
				if (tx_reps != '0) begin
					tx_bit = '0;
					enter_seg(SEG_HEAD_HI);
					return 1'b0;
				end
			end
			tx_mode  = TX_IDLE;
			tx_step  = SEG_HEAD_HI;
			tx_timer = '0;
			tx_line  = 1'b0;
			return 1'b1;
		end
		enter_seg(tx_step + 3'd1);
		return 1'b0;
	endfunction

	function automatic res_t predict_tick(input logic [ACTION_W-1:0] act,
	                                      input logic [CODE_W-1:0] code,
	                                      input logic [IDX_W-1:0] idx,
	                                      input logic [SYM_W-1:0] val);
		res_t r;
		r = '0;
		// Command decode; anything while busy is refused
		if (act != ACT_TICK) begin
			if (tx_mode != TX_IDLE) begin
				r.rejected = 1'b1;
			end else if (act == ACT_CODE) begin
				if (code == '0 || code[CODE_W-1:CODE_TOP_BIT] != '0) begin
					r.rejected = 1'b1;
				end else begin
					tx_mode = TX_CODE;
					tx_code = code;
					tx_bit  = '0;
					tx_reps = (tx_cfg.repeat_count == '0) ? 8'd1 : tx_cfg.repeat_count;
					enter_seg(SEG_HEAD_HI);
				end
			end else if (act == ACT_SYM_WR) begin
				if (idx < SYMBOLS)
					tx_syms[idx] = val;
				else
					r.rejected = 1'b1;
			end else begin
				tx_mode    = TX_SYM;
				tx_sym_pos = '0;
				tx_bit     = '0;
				enter_seg(SEG_HEAD_HI);
			end
		end
		// This tick of the running transmission
		if (tx_mode != TX_IDLE) begin
			r.line_level = tx_line;
			if (tx_timer != '0)
				tx_timer--;
			if (tx_timer == '0)
				r.done_res = next_seg();
		end
		r.busy_res = (tx_mode != TX_IDLE);
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	// Offer one item; its expectation is queued before it can be accepted
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CODE_W-1:0] code,
	                         input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] val);
		logic [DATA_W-1:0] word;
		int gap;
		word = '0;
		word[CODE_W-1:0] = code;
		word[CODE_W +: IDX_W] = idx;
		word[CODE_W + IDX_W +: SYM_W] = val;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		s_tuser  <= act;
		expected_line_states.push_back(predict_tick(act, code, idx, val));
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_line_states.size() != 0);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Rewrite every timing register once the block has gone quiet
	task automatic apply_timing(input cfg_t c);
		wait_for_drain();
		put_reg(REG_REPEAT, c.repeat_count);
		put_reg(REG_PULSE_HIGH, c.pulse_high_ticks);
		put_reg(REG_SHORT_LOW, c.short_low_ticks);
		put_reg(REG_LONG_LOW, c.long_low_ticks);
		put_reg(REG_START_LOW, c.start_low_ticks);
		put_reg(REG_END_LOW, c.end_low_ticks);
		put_reg(REG_UNIT, c.unit_ticks);
		cfg_we <= 1'b0;
		tx_cfg = c;
		@(posedge clk);
	endtask

	function automatic cfg_t make_timing(input int rep, input int hi, input int sh, input int lg,
	                                     input int st, input int en, input int u);
		cfg_t c;
		c.repeat_count     = REPEAT_W'(rep);
		c.pulse_high_ticks = TIMER_W'(hi);
		c.short_low_ticks  = TIMER_W'(sh);
		c.long_low_ticks   = TIMER_W'(lg);
		c.start_low_ticks  = TIMER_W'(st);
		c.end_low_ticks    = TIMER_W'(en);
		c.unit_ticks       = UNIT_W'(u);
		return c;
	endfunction

	function automatic logic [ACTION_W-1:0] pick_command();
		case ($urandom_range(2))
			0: return ACT_CODE;
			1: return ACT_SYM_WR;
			default: return ACT_SYM_GO;
		endcase
	endfunction

	// Tick until the transmission ends, with stray commands mixed in
	task automatic run_until_idle(input int cmd_pct);
		while (tx_mode != TX_IDLE) begin
			if ($urandom_range(99) < cmd_pct)
				send_item(pick_command(), $urandom, $urandom, $urandom);
			else
				send_item(ACT_TICK, $urandom, $urandom, $urandom);
		end
	endtask

	// ---------------- tests ----------------

	// Idle ticks, refused codes, bad index, fill of the symbol buffer
	task automatic test_idle_commands();
		send_item(ACT_TICK, '1, '1, '1);
		send_item(ACT_TICK, '0, '0, '0);
		send_item(ACT_CODE, 32'h0000_0000, '0, '0);
		send_item(ACT_CODE, 32'h1000_0000, '0, '0);
		send_item(ACT_CODE, 32'hFFFF_FFFF, '1, '1);
		send_item(ACT_CODE, 32'h8000_0000, '0, '0);
		send_item(ACT_SYM_WR, '0, 5'd31, '1);
		for (int i = 0; i < SYMBOLS; i++)
			send_item(ACT_SYM_WR, $urandom, IDX_W'(i), SYM_W'(i * 13));
		send_item(ACT_TICK, $urandom, $urandom, $urandom);
	endtask

	// Code frame sent twice: zero pulse, start and end gap registers, every command while busy
	task automatic test_code_frame();
		apply_timing(make_timing(2, 0, 1, 2, 0, 0, 0));
		send_item(ACT_CODE, 32'h0A5C_3E01, '0, '0);
		send_item(ACT_CODE, 32'h0000_0002, '0, '0);
		send_item(ACT_CODE, 32'h0000_0000, '0, '0);
		send_item(ACT_SYM_WR, '0, 5'd3, 5'd7);
		send_item(ACT_SYM_GO, '0, '0, '0);
		run_until_idle(10);
	endtask

	// Symbol frame with unit zero; pulse, short and long code timings parked at maximum
	task automatic test_symbol_frame();
		apply_timing(make_timing(1, 65535, 65535, 65535, 1, 1, 0));
		send_item(ACT_SYM_GO, '0, '0, '0);
		send_item(ACT_SYM_GO, '0, '0, '0);
		send_item(ACT_SYM_WR, '0, 5'd0, '0);
		send_item(ACT_CODE, 32'h0000_0055, '0, '0);
		run_until_idle(5);
	endtask

	// Long receiver hold while items keep coming, then a full drain
	task automatic test_backpressure();
		hold_left = 300;
		for (int i = 0; i < HOLD_ITEMS; i++) begin
			if (i % 4 == 0)
				send_item(ACT_CODE, 32'h1000_0000, IDX_W'(i), SYM_W'(i));
			else
				send_item(ACT_TICK, $urandom, $urandom, $urandom);
		end
		wait_for_drain();
	endtask

	initial begin
		model_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct  = 15;
		sink_idle_pct = 46;
		test_idle_commands();
		test_code_frame();
		src_idle_pct  = 46;
		sink_idle_pct = 15;
		test_symbol_frame();
		wait_for_drain();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_backpressure();
		wait_for_drain();
		repeat (PIPE_SLACK) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
